>>> hw/rtl/preset_crossfade_engine_defines.svh
// Assertion macros for the preset cross-fade engine.
// Expects clk and arst_n in the scope of each use; define ASSERT_OFF to drop checks.
`ifndef PRESET_CROSSFADE_ENGINE_DEFINES_SVH
`define PRESET_CROSSFADE_ENGINE_DEFINES_SVH

`ifndef ASSERT_OFF
// implication or plain property checked every clock outside reset
`define PCF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// condition that must never be true outside reset
`define PCF_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define PCF_ASSERT(lbl, prop, msg)
`define PCF_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

>>> hw/rtl/pcf_pkg.sv
// Shared types, opcodes and the preset ROM of the preset cross-fade engine.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps
`default_nettype none

package pcf_pkg;

	typedef logic [1:0]  opcode_t;
	typedef logic [3:0]  preset_req_t;
	typedef logic [2:0]  preset_t;
	typedef logic [31:0] time_t;
	typedef logic [15:0] value_t;
	typedef logic [16:0] progress_t;

	localparam opcode_t OP_SET   = 2'd0;
	localparam opcode_t OP_TICK  = 2'd1;
	localparam opcode_t OP_RESET = 2'd2;

	localparam progress_t FULL_PROGRESS = 17'h10000;
	localparam int        OUT_CHANNELS  = 7;
	localparam int        PROG_BITS     = 16;
	localparam int        DIV_CNT_W     = 4;

	// Q4.12 presets: ambient, particle, red, green, blue, wind, fog, spare
	localparam value_t PRESET_ROM [8][8] = '{
		'{16'd4096, 16'd0,     16'd4096, 16'd4096, 16'd4096, 16'd410,  16'd4096,  16'd0},
		'{16'd3482, 16'd0,     16'd3482, 16'd3604, 16'd3768, 16'd1024, 16'd4915,  16'd0},
		'{16'd2867, 16'd4096,  16'd2867, 16'd3072, 16'd3482, 16'd2048, 16'd5734,  16'd0},
		'{16'd2253, 16'd8192,  16'd2253, 16'd2458, 16'd2867, 16'd2867, 16'd7373,  16'd0},
		'{16'd3686, 16'd4915,  16'd3891, 16'd3973, 16'd4301, 16'd1229, 16'd5325,  16'd0},
		'{16'd2048, 16'd10240, 16'd1843, 16'd2048, 16'd2458, 16'd4096, 16'd8192,  16'd0},
		'{16'd3277, 16'd0,     16'd3482, 16'd3482, 16'd3482, 16'd614,  16'd16384, 16'd0},
		'{16'd2048, 16'd6144,  16'd4506, 16'd3482, 16'd2253, 16'd4096, 16'd12288, 16'd0}
	};

	// rows 8 and up repeat preset 0
	function automatic value_t rom_value(input logic [3:0] row, input logic [2:0] col);
		logic [2:0] r;
		begin
			r = row[3] ? 3'd0 : row[2:0];
			return PRESET_ROM[r][col];
		end
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/pcf_cmd_if.sv
// Command channel of the preset cross-fade engine: valid/ready plus command fields.
// Depends on pcf_pkg for field types.
`timescale 1ns / 1ps
`default_nettype none

interface pcf_cmd_if;
	logic                 valid;
	logic                 ready;
	pcf_pkg::opcode_t     opcode;
	pcf_pkg::preset_req_t preset;
	pcf_pkg::time_t       fade_time;
	pcf_pkg::time_t       time_step;

	modport source (output valid, output opcode, output preset, output fade_time,
		output time_step, input ready);
	modport sink (input valid, input opcode, input preset, input fade_time,
		input time_step, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/pcf_rsp_if.sv
// Result channel of the preset cross-fade engine: valid/ready plus blended values.
// Depends on pcf_pkg for field types.
`timescale 1ns / 1ps
`default_nettype none

interface pcf_rsp_if;
	logic                valid;
	logic                ready;
	pcf_pkg::value_t     ambient_level;
	pcf_pkg::value_t     particle_rate;
	pcf_pkg::value_t     tint_red;
	pcf_pkg::value_t     tint_green;
	pcf_pkg::value_t     tint_blue;
	pcf_pkg::value_t     wind_level;
	pcf_pkg::value_t     fog_level;
	pcf_pkg::progress_t  progress;
	pcf_pkg::preset_t    target_preset;
	pcf_pkg::preset_t    settled_preset;

	modport source (output valid, output ambient_level, output particle_rate,
		output tint_red, output tint_green, output tint_blue, output wind_level,
		output fog_level, output progress, output target_preset, output settled_preset,
		input ready);
	modport sink (input valid, input ambient_level, input particle_rate,
		input tint_red, input tint_green, input tint_blue, input wind_level,
		input fog_level, input progress, input target_preset, input settled_preset,
		output ready);
endinterface

`default_nettype wire

>>> hw/rtl/preset_crossfade_engine.sv
// Preset cross-fade engine top level: sequencer, shared blend multiplier, progress divider.
// Depends on pcf_pkg, pcf_cmd_if, pcf_rsp_if and preset_crossfade_engine_defines.svh.
//
// Usage:
//   cmd (sink) takes one transaction per command: opcode 0 sets a target preset with a
//   fade length, opcode 1 advances time by time_step, opcode 2 snaps back to preset 0.
//   rsp (source) returns exactly one transaction per command: the seven blended Q4.12
//   parameters, progress in Q1.16 (65536 = settled) and the target and settled presets.
//   cmd.ready is high only while the sequencer is idle. A command that finishes or
//   changes nothing needs only the result blend pass; one that starts a fade runs a
//   blend pass first to capture the start values, and a tick inside a fade first runs the
//   restoring divider for elapsed/length. The blend pass runs one channel per cycle
//   through a single 17x18 multiplier followed by a rounding adder.
//   The result sits in an output register; the next command is taken while it waits.
//   If rsp is still stalled when the next result is due, the sequencer holds before its
//   blend pass until the register is taken.
//   Reset (arst_n low) settles the block at preset 0 with progress 65536 and drops any
//   pending result.
`timescale 1ns / 1ps
`default_nettype none
`include "preset_crossfade_engine_defines.svh"

module preset_crossfade_engine #(
	parameter int PRESET_COUNT  = 8,
	parameter int CHANNEL_COUNT = 7,
	parameter int TIME_BITS     = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	pcf_cmd_if.sink   cmd,
	pcf_rsp_if.source rsp
);

	localparam int KIND_W = (PRESET_COUNT > 2) ? $clog2(PRESET_COUNT) : 1;
	localparam int IDX_W  = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
	localparam int CH_W   = $clog2(CHANNEL_COUNT + 1);
	localparam int TW1    = TIME_BITS + 1;
	localparam int DIV_CNT_W_L = pcf_pkg::DIV_CNT_W;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EXEC  = 3'd1;
	localparam logic [2:0] ST_SNAP  = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_WAIT  = 3'd4;
	localparam logic [2:0] ST_BLEND = 3'd5;

	// control and fade state
	logic [2:0]               state_q;
	logic [CH_W-1:0]          ch_q;
	logic [DIV_CNT_W_L-1:0]   div_cnt_q;
	logic                     out_valid_q;
	logic [KIND_W-1:0]        settled_q;
	logic [KIND_W-1:0]        target_q;
	pcf_pkg::value_t          start_q [CHANNEL_COUNT];
	logic [TIME_BITS-1:0]     fade_len_q;
	logic [TIME_BITS-1:0]     elapsed_q;
	logic [TIME_BITS-1:0]     rem_q;
	pcf_pkg::progress_t       progress_q;
	logic                     vld_s1;

	// captured command
	pcf_pkg::opcode_t         op_q;
	pcf_pkg::preset_req_t     preset_q;
	logic [TIME_BITS-1:0]     req_len_q;
	logic [TIME_BITS-1:0]     dt_q;

	// datapath registers
	logic signed [34:0]       prod_s1;
	pcf_pkg::value_t          base_s1;
	logic [IDX_W-1:0]         idx_s1;
	logic [TIME_BITS-1:0]     div_rem_q;
	logic [pcf_pkg::PROG_BITS-1:0] quo_q;
	pcf_pkg::value_t          out_q [pcf_pkg::OUT_CHANNELS];
	pcf_pkg::progress_t       out_prog_q;
	pcf_pkg::preset_t         out_tgt_q;
	pcf_pkg::preset_t         out_set_q;

	logic                     cmd_fire;
	logic                     settled;
	logic [KIND_W-1:0]        kind_f;
	logic                     do_finish;
	logic                     do_snap;
	logic                     do_tick;
	logic [KIND_W-1:0]        fin_kind;

	logic [IDX_W-1:0]         unit_idx;
	pcf_pkg::value_t          unit_s;
	pcf_pkg::value_t          unit_g;
	logic signed [16:0]       unit_diff;
	logic signed [34:0]       unit_prod;
	logic                     unit_issue;
	logic                     unit_last;
	logic signed [34:0]       blend_rnd;
	logic signed [18:0]       blend_corr;
	logic signed [19:0]       blend_sum;
	pcf_pkg::value_t          blend_val;

	logic [TIME_BITS:0]       div_shift;
	logic                     div_ge;
	logic [TIME_BITS-1:0]     div_next;
	logic                     out_free;

	assign cmd_fire  = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == ST_IDLE);
	assign settled   = (progress_q == pcf_pkg::FULL_PROGRESS);
	assign out_free  = !out_valid_q || rsp.ready;

	// preset fold: out-of-range requests mean preset 0
	assign kind_f = ({1'b0, preset_q} < 5'(PRESET_COUNT)) ? KIND_W'(preset_q) : '0;

	// command decode
	always_comb begin
		do_finish = 1'b0;
		do_snap   = 1'b0;
		do_tick   = 1'b0;
		fin_kind  = kind_f;
		case (op_q)
			pcf_pkg::OP_SET: begin
				if (req_len_q == '0) begin
					do_finish = 1'b1;
				end else if (!settled && kind_f == target_q) begin
					do_finish = 1'b0;
				end else if (settled && kind_f == settled_q) begin
					do_finish = 1'b1;
				end else begin
					do_snap = 1'b1;
				end
			end
			pcf_pkg::OP_TICK: begin
				if (!settled && dt_q != '0) begin
					if (dt_q >= rem_q) begin
						do_finish = 1'b1;
						fin_kind  = target_q;
					end else begin
						do_tick = 1'b1;
					end
				end
			end
			pcf_pkg::OP_RESET: begin
				do_finish = 1'b1;
				fin_kind  = '0;
			end
			default: begin
				do_finish = 1'b0;
			end
		endcase
	end

	// shared blend unit, stage 1: diff times progress
	assign unit_idx   = ch_q[IDX_W-1:0];
	assign unit_s     = start_q[unit_idx];
	assign unit_g     = pcf_pkg::rom_value(4'(target_q), 3'(unit_idx));
	assign unit_diff  = $signed({1'b0, unit_g}) - $signed({1'b0, unit_s});
	assign unit_prod  = unit_diff * $signed({1'b0, progress_q});
	assign unit_issue = (ch_q < CH_W'(CHANNEL_COUNT));
	assign unit_last  = (ch_q == CH_W'(CHANNEL_COUNT));

	// stage 2: round and add back the start value
	assign blend_rnd  = prod_s1 + 35'sd32768;
	assign blend_corr = blend_rnd[34:16];
	assign blend_sum  = $signed({4'b0000, base_s1}) + $signed({blend_corr[18], blend_corr});
	assign blend_val  = blend_sum[15:0];

	// restoring divider step: elapsed / length, one quotient bit per cycle
	assign div_shift = {div_rem_q, 1'b0};
	assign div_ge    = (div_shift >= {1'b0, fade_len_q});
	assign div_next  = div_ge ? TIME_BITS'(div_shift - {1'b0, fade_len_q})
		: TIME_BITS'(div_shift);

	// sequencer and fade state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ch_q        <= '0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
			settled_q   <= '0;
			target_q    <= '0;
			for (int c = 0; c < CHANNEL_COUNT; c++) begin
				start_q[c] <= pcf_pkg::rom_value(4'd0, 3'(c));
			end
			fade_len_q  <= '0;
			elapsed_q   <= '0;
			rem_q       <= '0;
			progress_q  <= pcf_pkg::FULL_PROGRESS;
			vld_s1      <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			// a channel enters the blend pipe during the snap and blend passes
			vld_s1 <= ((state_q == ST_SNAP) || (state_q == ST_BLEND)) && unit_issue;
			case (state_q)
				ST_IDLE: begin
					if (cmd_fire) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					ch_q      <= '0;
					div_cnt_q <= '0;
					if (do_finish) begin
						settled_q <= fin_kind;
						target_q  <= fin_kind;
						for (int c = 0; c < CHANNEL_COUNT; c++) begin
							start_q[c] <= pcf_pkg::rom_value(4'(fin_kind), 3'(c));
						end
						fade_len_q <= '0;
						elapsed_q  <= '0;
						rem_q      <= '0;
						progress_q <= pcf_pkg::FULL_PROGRESS;
					end
					if (do_tick) begin
						elapsed_q <= elapsed_q + dt_q;
						rem_q     <= rem_q - dt_q;
					end
					if (do_snap) begin
						state_q <= ST_SNAP;
					end else if (do_tick) begin
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_WAIT;
					end
				end
				ST_SNAP: begin
					// capture the values shown now as the new start point
					if (vld_s1) begin
						start_q[idx_s1] <= blend_val;
					end
					if (unit_issue) begin
						ch_q <= ch_q + 1'b1;
					end
					if (unit_last) begin
						target_q   <= kind_f;
						fade_len_q <= req_len_q;
						rem_q      <= req_len_q;
						elapsed_q  <= '0;
						progress_q <= '0;
						state_q    <= ST_WAIT;
					end
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == DIV_CNT_W_L'(pcf_pkg::PROG_BITS - 1)) begin
						progress_q <= {1'b0, quo_q[pcf_pkg::PROG_BITS-2:0], div_ge};
						state_q    <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					ch_q <= '0;
					if (out_free) begin
						state_q <= ST_BLEND;
					end
				end
				ST_BLEND: begin
					if (unit_issue) begin
						ch_q <= ch_q + 1'b1;
					end
					if (unit_last) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload and datapath registers
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			op_q      <= cmd.opcode;
			preset_q  <= cmd.preset;
			req_len_q <= cmd.fade_time[TIME_BITS-1:0];
			dt_q      <= cmd.time_step[TIME_BITS-1:0];
		end
		prod_s1 <= unit_prod;
		base_s1 <= unit_s;
		idx_s1  <= unit_idx;
		if (state_q == ST_EXEC) begin
			div_rem_q <= elapsed_q + dt_q;
		end else if (state_q == ST_DIV) begin
			div_rem_q <= div_next;
			quo_q     <= {quo_q[pcf_pkg::PROG_BITS-2:0], div_ge};
		end
		if (state_q == ST_WAIT && out_free) begin
			out_prog_q <= progress_q;
			out_tgt_q  <= 3'(target_q);
			out_set_q  <= 3'(settled_q);
		end
		if (state_q == ST_BLEND && vld_s1 && (4'(idx_s1) < 4'(pcf_pkg::OUT_CHANNELS))) begin
			out_q[3'(idx_s1)] <= blend_val;
		end
	end

	// result channel
	assign rsp.valid          = out_valid_q;
	assign rsp.ambient_level  = (CHANNEL_COUNT > 0) ? out_q[0] : '0;
	assign rsp.particle_rate  = (CHANNEL_COUNT > 1) ? out_q[1] : '0;
	assign rsp.tint_red       = (CHANNEL_COUNT > 2) ? out_q[2] : '0;
	assign rsp.tint_green     = (CHANNEL_COUNT > 3) ? out_q[3] : '0;
	assign rsp.tint_blue      = (CHANNEL_COUNT > 4) ? out_q[4] : '0;
	assign rsp.wind_level     = (CHANNEL_COUNT > 5) ? out_q[5] : '0;
	assign rsp.fog_level      = (CHANNEL_COUNT > 6) ? out_q[6] : '0;
	assign rsp.progress       = out_prog_q;
	assign rsp.target_preset  = out_tgt_q;
	assign rsp.settled_preset = out_set_q;

	// checks
	`PCF_ASSERT(a_time_split, !settled |-> (TW1'(elapsed_q) + TW1'(rem_q) == TW1'(fade_len_q)), "elapsed plus remaining differs from fade length")
	`PCF_ASSERT(a_settled_same, settled |-> (target_q == settled_q && elapsed_q == '0), "settled with target differing from settled preset")
	`PCF_ASSERT_NEVER(a_blend_over, state_q == ST_BLEND && out_valid_q, "blend pass overwrote a pending result")
	`PCF_ASSERT(a_valid_src, $rose(out_valid_q) |-> $past(state_q == ST_BLEND), "result raised outside blend pass")

endmodule

`default_nettype wire

>>> dv/preset_crossfade_engine_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for preset_crossfade_engine: random command streams with a built-in
// scene predictor and per-field result checks. Needs pcf_pkg, pcf_cmd_if and pcf_rsp_if.

module preset_crossfade_engine_tb;
	import pcf_pkg::*;

	// opcode 3 is unused by the block and must leave the state alone
	localparam opcode_t OP_NOP      = 2'd3;
	localparam int      RAND_ITEMS  = 1350;
	localparam int      DRAIN_WAIT  = 40;

	typedef struct packed {
		opcode_t     op;
		preset_req_t preset;
		time_t       fade_time;
		time_t       time_step;
	} cmd_item_t;

	typedef struct packed {
		logic [6:0][15:0] lvl;
		progress_t        prog;
		preset_t          tgt;
		preset_t          stl;
	} scene_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	pcf_cmd_if cmd_bus ();
	pcf_rsp_if rsp_bus ();

	preset_crossfade_engine DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_bus),
		.rsp    (rsp_bus)
	);

	always #5 clk = ~clk;

	cmd_item_t   pending_cmds[$];
	scene_t      expected_scenes[$];
	int unsigned total_items = 1;
	int unsigned issued = 0;
	int unsigned mismatch_count = 0;
	bit          cmd_took = 1'b0;

	string chan_name[7] = '{"ambient_level", "particle_rate", "tint_red", "tint_green",
		"tint_blue", "wind_level", "fog_level"};

	// Scene state mirrored from the block
	preset_t   cur_settled;
	preset_t   cur_target;
	value_t    fade_origin[7];
	time_t     fade_len;
	time_t     fade_elapsed;
	progress_t fade_prog;

	// One channel: start value blended toward the target preset by the progress
	function automatic value_t mix_channel(input int ch);
		logic [63:0] s, g, p, v;
		begin
			s = fade_origin[ch];
			g = PRESET_ROM[cur_target][ch];
			p = (fade_prog > FULL_PROGRESS) ? FULL_PROGRESS : fade_prog;
			v = (s * (64'd65536 - p) + g * p + 64'd32768) >> 16;
			return v[15:0];
		end
	endfunction

	function automatic void settle_on(input preset_t k);
		begin
			cur_settled = k;
			cur_target = k;
			for (int c = 0; c < 7; c++)
				fade_origin[c] = PRESET_ROM[k][c];
			fade_len = '0;
			fade_elapsed = '0;
			fade_prog = FULL_PROGRESS;
		end
	endfunction

	function automatic void start_fade(input preset_req_t req, input time_t len);
		preset_t k;
		value_t  snap[7];
		begin
			k = req[3] ? 3'd0 : req[2:0];
			if (len == 0) begin
				settle_on(k);
			end else if (fade_prog < FULL_PROGRESS && k == cur_target) begin
				// same target while fading: keep going
			end else if (fade_prog >= FULL_PROGRESS && k == cur_settled) begin
				settle_on(k);
			end else begin
				// retarget from whatever is shown right now
				for (int c = 0; c < 7; c++)
					snap[c] = mix_channel(c);
				for (int c = 0; c < 7; c++)
					fade_origin[c] = snap[c];
				cur_target = k;
				fade_len = len;
				fade_elapsed = '0;
				fade_prog = '0;
			end
		end
	endfunction

	function automatic void advance_clock(input time_t dt);
		logic [47:0] quot;
		time_t       remaining;
		begin
			if (fade_prog >= FULL_PROGRESS || dt == 0)
				return;
			if (fade_len == 0 || fade_elapsed >= fade_len) begin
				settle_on(cur_target);
				return;
			end
			remaining = fade_len - fade_elapsed;
			if (dt >= remaining) begin
				settle_on(cur_target);
				return;
			end
			fade_elapsed = fade_elapsed + dt;
			quot = {fade_elapsed, 16'h0000} / {16'h0000, fade_len};
			fade_prog = quot[16:0];
		end
	endfunction

	function automatic scene_t apply_command(input cmd_item_t it);
		scene_t r;
		begin
			case (it.op)
				OP_SET:   start_fade(it.preset, it.fade_time);
				OP_TICK:  advance_clock(it.time_step);
				OP_RESET: settle_on(3'd0);
				default: ;
			endcase
			for (int c = 0; c < 7; c++)
				r.lvl[c] = mix_channel(c);
			r.prog = fade_prog;
			r.tgt = cur_target;
			r.stl = cur_settled;
			return r;
		end
	endfunction

	function automatic void note_mismatch(input string what, input longint unsigned want,
		input longint unsigned got);
		begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("%0t mismatch %s: expected %0d, got %0d", $realtime, what, want, got);
		end
	endfunction

	function automatic void check_scene(input scene_t got);
		scene_t want;
		begin
			if (expected_scenes.size() == 0) begin
				note_mismatch("unexpected result transaction", 0, 1);
				return;
			end
			want = expected_scenes.pop_front();
			for (int c = 0; c < 7; c++)
				if (got.lvl[c] !== want.lvl[c])
					note_mismatch(chan_name[c], want.lvl[c], got.lvl[c]);
			if (got.prog !== want.prog)
				note_mismatch("progress", want.prog, got.prog);
			if (got.tgt !== want.tgt)
				note_mismatch("target_preset", want.tgt, got.tgt);
			if (got.stl !== want.stl)
				note_mismatch("settled_preset", want.stl, got.stl);
		end
	endfunction

	task automatic queue_cmd(input opcode_t op, input preset_req_t p, input time_t ft,
		input time_t ts);
		cmd_item_t it;
		begin
			it.op = op;
			it.preset = p;
			it.fade_time = ft;
			it.time_step = ts;
			pending_cmds.push_back(it);
		end
	endtask

	// Monitor: predict on each accepted command, check each accepted result
	always @(posedge clk) begin : watch_bus
		scene_t got;
		cmd_item_t it;
		if (arst_n) begin
			cmd_took = cmd_bus.valid && cmd_bus.ready;
			if (cmd_took) begin
				it.op = cmd_bus.opcode;
				it.preset = cmd_bus.preset;
				it.fade_time = cmd_bus.fade_time;
				it.time_step = cmd_bus.time_step;
				expected_scenes.push_back(apply_command(it));
			end
			if (rsp_bus.valid && rsp_bus.ready) begin
				got.lvl[0] = rsp_bus.ambient_level;
				got.lvl[1] = rsp_bus.particle_rate;
				got.lvl[2] = rsp_bus.tint_red;
				got.lvl[3] = rsp_bus.tint_green;
				got.lvl[4] = rsp_bus.tint_blue;
				got.lvl[5] = rsp_bus.wind_level;
				got.lvl[6] = rsp_bus.fog_level;
				got.prog = rsp_bus.progress;
				got.tgt = rsp_bus.target_preset;
				got.stl = rsp_bus.settled_preset;
				check_scene(got);
			end
		end
	end

	// Driver: command valid and result ready, idling by phase
	// phases: 0 none, 1 sender idle 82%, 2 receiver stall 82%, 3 both 9%
	always @(negedge clk) begin : feed_cmd
		cmd_item_t   nxt;
		int unsigned mode;
		int unsigned idle_pct;
		int unsigned stall_pct;
		if (arst_n) begin
			mode = (issued * 4) / total_items;
			if (mode > 3)
				mode = 3;
			idle_pct = (mode == 1) ? 82 : (mode == 3) ? 9 : 0;
			stall_pct = (mode == 2) ? 82 : (mode == 3) ? 9 : 0;
			if (!cmd_bus.valid || cmd_took) begin
				if (pending_cmds.size() != 0 && $urandom_range(99, 0) >= idle_pct) begin
					nxt = pending_cmds.pop_front();
					cmd_bus.opcode <= nxt.op;
					cmd_bus.preset <= nxt.preset;
					cmd_bus.fade_time <= nxt.fade_time;
					cmd_bus.time_step <= nxt.time_step;
					cmd_bus.valid <= 1'b1;
					issued++;
				end else begin
					cmd_bus.valid <= 1'b0;
				end
			end
			rsp_bus.ready <= ($urandom_range(99, 0) >= stall_pct);
		end
	end

	// Stimulus, reset and end of run
	initial begin : run_test
		time_t       len;
		time_t       dt;
		longint unsigned step_max;
		int unsigned pick;
		int unsigned ticks;
		int unsigned random_start;

		cmd_bus.valid = 1'b0;
		cmd_bus.opcode = OP_SET;
		cmd_bus.preset = '0;
		cmd_bus.fade_time = '0;
		cmd_bus.time_step = '0;
		rsp_bus.ready = 1'b0;
		settle_on(3'd0);

		// directed: settled tick, instant switches, retargets, exact completions
		queue_cmd(OP_TICK, 4'd0, 32'd0, 32'd5);
		queue_cmd(OP_SET, 4'd3, 32'd0, 32'd0);
		queue_cmd(OP_SET, 4'd3, 32'd100, 32'd0);
		queue_cmd(OP_SET, 4'd5, 32'd1000, 32'd0);
		queue_cmd(OP_TICK, 4'd0, 32'd0, 32'd0);
		queue_cmd(OP_TICK, 4'd0, 32'd0, 32'd250);
		queue_cmd(OP_SET, 4'd5, 32'd7, 32'd0);
		queue_cmd(OP_TICK, 4'd0, 32'd0, 32'd250);
		queue_cmd(OP_SET, 4'd7, 32'hFFFF_FFFF, 32'd0);
		queue_cmd(OP_TICK, 4'd0, 32'd0, 32'd1);
		queue_cmd(OP_TICK, 4'd0, 32'd0, 32'hFFFF_FFFE);
		queue_cmd(OP_NOP, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_cmd(OP_SET, 4'd15, 32'd64, 32'd0);
		queue_cmd(OP_TICK, 4'd0, 32'd0, 32'd63);
		queue_cmd(OP_TICK, 4'd0, 32'd0, 32'd1);
		queue_cmd(OP_SET, 4'd9, 32'd0, 32'd0);
		queue_cmd(OP_SET, 4'd6, 32'd3, 32'd0);
		queue_cmd(OP_RESET, 4'd6, 32'd3, 32'd1);
		queue_cmd(OP_SET, 4'd1, 32'hFFFF_FFFF, 32'd0);
		queue_cmd(OP_TICK, 4'd0, 32'd0, 32'hFFFF_FFFF);
		for (int k = 0; k < 8; k++)
			queue_cmd(OP_SET, k[3:0], 32'd2, 32'd0);

		// random: mostly fades followed by ticks, with retargets and noise mixed in
		random_start = pending_cmds.size();
		while (pending_cmds.size() < random_start + RAND_ITEMS) begin
			pick = $urandom_range(99, 0);
			if (pick < 65) begin
				case ($urandom_range(3, 0))
					0: len = $urandom_range(16, 1);
					1: len = $urandom_range(5000, 17);
					2: len = $urandom;
					default: len = $urandom_range(256, 1);
				endcase
				queue_cmd(OP_SET, 4'($urandom_range(15, 0)), len, $urandom);
				ticks = $urandom_range(10, 1);
				step_max = (64'(len) * 2) / ticks;
				if (step_max == 0)
					step_max = 1;
				if (step_max > 64'hFFFF_FFFF)
					step_max = 64'hFFFF_FFFF;
				for (int t = 0; t < ticks; t++) begin
					pick = $urandom_range(99, 0);
					if (pick < 6) begin
						dt = '0;
					end else if (pick < 10) begin
						dt = 32'hFFFF_FFFF;
					end else if (pick < 18) begin
						queue_cmd(OP_SET, 4'($urandom_range(15, 0)), len, $urandom);
						continue;
					end else begin
						dt = $urandom_range(step_max[31:0], 1);
					end
					queue_cmd(OP_TICK, 4'($urandom_range(15, 0)), $urandom, dt);
				end
			end else if (pick < 80) begin
				if ($urandom_range(1, 0))
					queue_cmd(OP_RESET, 4'($urandom_range(15, 0)), $urandom, $urandom);
				else
					queue_cmd(OP_SET, 4'($urandom_range(15, 0)), 32'd0, $urandom);
			end else begin
				queue_cmd(2'($urandom_range(3, 0)), 4'($urandom_range(15, 0)), $urandom,
					$urandom);
			end
		end
		total_items = pending_cmds.size();

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_cmds.size() != 0 || cmd_bus.valid)
			@(posedge clk);
		while (expected_scenes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (mismatch_count == 0 && expected_scenes.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#(64'd10_000_000);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
